// ===== design/lsbm_pkg.sv =====
// ============================================================================
// lsbm_pkg
// Types and constants shared by the latch switched bank mapper.
// ============================================================================
package lsbm_pkg;

    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned MAP_W    = 18;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 5;

    typedef enum logic [1:0] {
        MODE_CPU_RD = 2'd0,
        MODE_CPU_WR = 2'd1,
        MODE_PPU_RD = 2'd2,
        MODE_PPU_WR = 2'd3
    } access_mode_t;

    typedef enum logic [2:0] {
        TGT_NONE    = 3'd0,
        TGT_PRG_RAM = 3'd1,
        TGT_PRG_ROM = 3'd2,
        TGT_CHR     = 3'd3,
        TGT_VRAM    = 3'd4
    } target_t;

    // Configuration register indexes. Index 2 (nametable arrangement) only
    // acts through reset, which restores its default, so it is not stored.
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_UNITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_RAM   = 2'd1;

    localparam logic [4:0] PRG_UNITS_RESET = 5'd8;
    localparam logic       VERTICAL_RESET  = 1'b1;

    // CHR latch trigger addresses
    localparam logic [ADDR_W-1:0] LOW_FD_TRIG  = 16'h0FD8;
    localparam logic [ADDR_W-1:0] LOW_FE_TRIG  = 16'h0FE8;
    localparam logic [11:0]       HIGH_FD_ROW  = 12'h1FD;
    localparam logic [11:0]       HIGH_FE_ROW  = 12'h1FE;

    // CPU write decode on address bits 15:12
    localparam logic [3:0] REG_PRG     = 4'hA;
    localparam logic [3:0] REG_LOW_FD  = 4'hB;
    localparam logic [3:0] REG_LOW_FE  = 4'hC;
    localparam logic [3:0] REG_HIGH_FD = 4'hD;
    localparam logic [3:0] REG_HIGH_FE = 4'hE;
    localparam logic [3:0] REG_MIRROR  = 4'hF;

    // CPU window decode on address bits 15:13
    localparam logic [2:0] WIN_PRG_RAM = 3'b011;
    localparam logic [2:0] WIN_PRG_SW  = 3'b100;
    localparam logic [2:0] WIN_FIX_A   = 3'b101;
    localparam logic [2:0] WIN_FIX_C   = 3'b110;
    localparam logic [2:0] WIN_FIX_E   = 3'b111;

    typedef struct packed {
        access_mode_t        mode;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   write_data;
    } item_t;

    typedef struct packed {
        target_t             target;
        logic [MAP_W-1:0]    mapped_address;
    } result_t;

    typedef struct packed {
        logic [4:0] prg_units;
        logic       chr_ram;
        logic [3:0] prg_select;
        logic [4:0] chr_low_fd;
        logic [4:0] chr_low_fe;
        logic [4:0] chr_high_fd;
        logic [4:0] chr_high_fe;
        logic       horiz_mirror;
        logic       low_latch_fd;
        logic       high_latch_fd;
    } map_state_t;

endpackage

// ===== design/lsbm_req_if.sv =====
// ============================================================================
// lsbm_req_if
// Bus access item channel: access kind, address and write byte.
// ============================================================================
interface lsbm_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic [lsbm_pkg::ADDR_W-1:0]   address;
    logic [lsbm_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, output mode, output address, output write_data,
                    input ready);
    modport sink   (input valid, input mode, input address, input write_data,
                    output ready);
endinterface

// ===== design/lsbm_rsp_if.sv =====
// ============================================================================
// lsbm_rsp_if
// Translation result channel: target memory and offset.
// ============================================================================
interface lsbm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    target;
    logic [lsbm_pkg::MAP_W-1:0]    mapped_address;

    modport source (output valid, output target, output mapped_address, input ready);
    modport sink   (input valid, input target, input mapped_address, output ready);
endinterface

// ===== design/lsbm_cfg_if.sv =====
// ============================================================================
// lsbm_cfg_if
// Configuration write channel: register index and data.
// ============================================================================
interface lsbm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lsbm_pkg::CFG_IDX_W-1:0]   index;
    logic [lsbm_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/lsbm_bank_regs.sv =====
// ============================================================================
// lsbm_bank_regs
// Configuration, bank select registers, mirroring and the two CHR latches.
// ============================================================================
module lsbm_bank_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lsbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lsbm_pkg::CFG_DAT_W-1:0]      cfg_data,
    input  logic                                accept,
    input  lsbm_pkg::item_t                     item,
    output lsbm_pkg::map_state_t                state
);
    import lsbm_pkg::*;

    map_state_t state_reg;
    map_state_t state_next;
    logic [3:0] wr_sel;

    assign wr_sel = item.address[15:12];

    always_comb
    begin
        state_next = state_reg;
        if (cfg_we)
        begin
            if (cfg_index == CFG_PRG_UNITS)
            begin
                state_next.prg_units = cfg_data;
            end
            else if (cfg_index == CFG_CHR_RAM)
            begin
                state_next.chr_ram = cfg_data[0];
            end
        end
        if (accept)
        begin
            if (item.mode == MODE_CPU_WR)
            begin
                unique case (wr_sel)
                    REG_PRG:     state_next.prg_select   = item.write_data[3:0];
                    REG_LOW_FD:  state_next.chr_low_fd   = item.write_data[4:0];
                    REG_LOW_FE:  state_next.chr_low_fe   = item.write_data[4:0];
                    REG_HIGH_FD: state_next.chr_high_fd  = item.write_data[4:0];
                    REG_HIGH_FE: state_next.chr_high_fe  = item.write_data[4:0];
                    REG_MIRROR:  state_next.horiz_mirror = item.write_data[0];
                    default:     ;
                endcase
            end
            else if (item.mode == MODE_PPU_RD)
            begin
                // low half triggers on exact address, high half on 8-byte rows
                if (item.address == LOW_FD_TRIG)
                begin
                    state_next.low_latch_fd = 1'b1;
                end
                else if (item.address == LOW_FE_TRIG)
                begin
                    state_next.low_latch_fd = 1'b0;
                end
                if (item.address[15:4] == HIGH_FD_ROW && item.address[3])
                begin
                    state_next.high_latch_fd = 1'b1;
                end
                else if (item.address[15:4] == HIGH_FE_ROW && item.address[3])
                begin
                    state_next.high_latch_fd = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.prg_units     <= PRG_UNITS_RESET;
            state_reg.chr_ram       <= 1'b0;
            state_reg.prg_select    <= '0;
            state_reg.chr_low_fd    <= '0;
            state_reg.chr_low_fe    <= '0;
            state_reg.chr_high_fd   <= '0;
            state_reg.chr_high_fe   <= '0;
            state_reg.horiz_mirror  <= ~VERTICAL_RESET;
            state_reg.low_latch_fd  <= 1'b0;
            state_reg.high_latch_fd <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

// ===== design/lsbm_translate.sv =====
// ============================================================================
// lsbm_translate
// Maps one bus access to a target memory and offset from current bank state.
// ============================================================================
module lsbm_translate (
    input  lsbm_pkg::item_t        item,
    input  lsbm_pkg::map_state_t   state,
    output lsbm_pkg::result_t      result
);
    import lsbm_pkg::*;

    logic [ADDR_W-1:0] a;
    logic [4:0]        last_bank;
    logic [4:0]        fix_bank;
    logic [4:0]        chr_bank;
    logic [10:0]       nt_addr;
    logic              win_ok;

    assign a = item.address;
    // last 8 KB bank of ROM, wrapping over 32 banks
    assign last_bank = {state.prg_units[3:0], 1'b0} - 5'd1;

    always_comb
    begin
        unique case (a[14:13])
            2'b01:   fix_bank = last_bank - 5'd2;
            2'b10:   fix_bank = last_bank - 5'd1;
            default: fix_bank = last_bank;
        endcase
    end

    assign chr_bank = a[12]
        ? (state.high_latch_fd ? state.chr_high_fd : state.chr_high_fe)
        : (state.low_latch_fd  ? state.chr_low_fd  : state.chr_low_fe);

    assign nt_addr = {(state.horiz_mirror ? a[11] : a[10]), a[9:0]};
    assign win_ok  = (a[15:13] == 3'b000);

    always_comb
    begin
        result.target         = TGT_NONE;
        result.mapped_address = '0;
        unique case (item.mode)
            MODE_CPU_RD:
            begin
                unique case (a[15:13])
                    WIN_PRG_RAM:
                    begin
                        result.target         = TGT_PRG_RAM;
                        result.mapped_address = {5'd0, a[12:0]};
                    end
                    WIN_PRG_SW:
                    begin
                        result.target         = TGT_PRG_ROM;
                        result.mapped_address = {1'b0, state.prg_select, a[12:0]};
                    end
                    WIN_FIX_A, WIN_FIX_C, WIN_FIX_E:
                    begin
                        result.target         = TGT_PRG_ROM;
                        result.mapped_address = {fix_bank, a[12:0]};
                    end
                    default: ;
                endcase
            end
            MODE_CPU_WR:
            begin
                if (a[15:13] == WIN_PRG_RAM)
                begin
                    result.target         = TGT_PRG_RAM;
                    result.mapped_address = {5'd0, a[12:0]};
                end
            end
            MODE_PPU_RD:
            begin
                if (win_ok)
                begin
                    result.target         = TGT_CHR;
                    result.mapped_address = {1'b0, chr_bank, a[11:0]};
                end
                else
                begin
                    result.target         = TGT_VRAM;
                    result.mapped_address = {7'd0, nt_addr};
                end
            end
            MODE_PPU_WR:
            begin
                if (win_ok)
                begin
                    if (state.chr_ram)
                    begin
                        result.target         = TGT_CHR;
                        result.mapped_address = {5'd0, a[12:0]};
                    end
                end
                else
                begin
                    result.target         = TGT_VRAM;
                    result.mapped_address = {7'd0, nt_addr};
                end
            end
        endcase
    end

endmodule

// ===== design/lsbm_out_buf.sv =====
// ============================================================================
// lsbm_out_buf
// Result register with a skid stage so input can keep flowing under stall.
// ============================================================================
module lsbm_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  lsbm_pkg::result_t     load_data,
    output logic                  load_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lsbm_pkg::result_t     out_data,
    output logic                  skid_busy
);
    import lsbm_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = load_data;
                out_valid_next = load;
            end
        end
        else if (load)
        begin
            skid_data_next  = load_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign load_ready = ~skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign skid_busy  = skid_valid_reg;

endmodule

// ===== design/latch_switched_bank_mapper.sv =====
// ============================================================================
// latch_switched_bank_mapper
// Latch switched cartridge bank mapper: translates CPU/PPU bus accesses.
//
//   channel | dir | handshake   | payload
//   --------+-----+-------------+----------------------------------------
//   cfg     | in  | valid/ready | index, data (always ready)
//   req     | in  | valid/ready | mode, address, write_data
//   rsp     | out | valid/ready | target, mapped_address
//
// One item per cycle while req.ready is high; each accepted item's result is registered.
// Bank registers and CHR latches update at the accepting edge, so the next
// item in the following cycle already sees them.
// A skid stage behind the result register keeps req ready for one item
// while rsp is stalled; req.ready drops only when that stage is full.
// Reset clears banks and latches (FE selected) and restores configuration.
// ============================================================================
module latch_switched_bank_mapper (
    input  logic         clk,
    input  logic         rst_n,
    lsbm_cfg_if.sink     cfg,
    lsbm_req_if.sink     req,
    lsbm_rsp_if.source   rsp
);
    import lsbm_pkg::*;

    item_t      item;
    map_state_t state;
    result_t    result;
    result_t    rsp_data;
    logic       req_accept;
    logic       load_ready;
    logic       skid_busy;

    assign item.mode       = access_mode_t'(req.mode);
    assign item.address    = req.address;
    assign item.write_data = req.write_data;

    assign req.ready  = load_ready;
    assign req_accept = req.valid && load_ready;
    assign cfg.ready  = 1'b1;

    lsbm_bank_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .accept    (req_accept),
        .item      (item),
        .state     (state)
    );

    lsbm_translate u_xlate (
        .item   (item),
        .state  (state),
        .result (result)
    );

    lsbm_out_buf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (req_accept),
        .load_data  (result),
        .load_ready (load_ready),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_data   (rsp_data),
        .skid_busy  (skid_busy)
    );

    assign rsp.target         = rsp_data.target;
    assign rsp.mapped_address = rsp_data.mapped_address;

    // skid stage never holds an item unless the result register does too
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_busy |-> rsp.valid)
        else $error("skid stage full while result register empty");

    a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> rsp.valid)
        else $error("accepted item produced no result");

    a_prg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && item.mode == MODE_CPU_WR && req.address[15:12] == REG_PRG)
        |=> state.prg_select == $past(req.write_data[3:0]))
        else $error("PRG bank register not loaded");

    a_low_latch: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(state.low_latch_fd) |->
        $past(req_accept && item.mode == MODE_PPU_RD
              && (req.address == LOW_FD_TRIG || req.address == LOW_FE_TRIG)))
        else $error("low CHR latch moved without a trigger fetch");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the latch switched bank mapper.
// A directed table covers window edges, register writes and CHR latch
// triggers. Biased random accesses follow under several configurations.
// Every accepted access is run through a local bank/latch predictor, and
// each result is compared field by field, in order. Both sides idle at
// random, and one phase holds off the result side for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lsbm_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int NUM_PHASES = 8;
    localparam int LONG_HOLD = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRANGE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

    typedef struct {
        item_t   acc;
        bit      pinned;
        result_t want;
    } probe_t;

    typedef struct packed {
        logic    pinned;
        result_t res;
    } pin_t;

    logic clk = 1'b0;
    logic rst_n;

    lsbm_cfg_if cfg_ch ();
    lsbm_req_if req_ch ();
    lsbm_rsp_if rsp_ch ();

    latch_switched_bank_mapper dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // predictor state
    map_state_t bank_state;
    logic       arrange_vertical;

    result_t pending_maps[$];
    pin_t    pinned_maps[$];
    probe_t  probes[$];

    int  mismatches = 0;
    int  cycles = 0;
    bit  no_wait = 1'b0;
    bit  hold_rsp = 1'b0;

    function automatic result_t translate_access(item_t acc);
        result_t     r;
        logic [15:0] a;
        logic [4:0]  bank;
        a = acc.address;
        r.target = TGT_NONE;
        r.mapped_address = '0;
        case (acc.mode)
            MODE_CPU_RD:
            begin
                case (a[15:13])
                    WIN_PRG_RAM:
                    begin
                        r.target = TGT_PRG_RAM;
                        r.mapped_address = {5'd0, a[12:0]};
                    end
                    WIN_PRG_SW:
                    begin
                        r.target = TGT_PRG_ROM;
                        r.mapped_address = {1'b0, bank_state.prg_select, a[12:0]};
                    end
                    WIN_FIX_A, WIN_FIX_C, WIN_FIX_E:
                    begin
                        // last three 8 KB banks, wrapping at 32 banks
                        if (a[15:13] == WIN_FIX_A)
                            bank = {bank_state.prg_units[3:0], 1'b0} - 5'd3;
                        else if (a[15:13] == WIN_FIX_C)
                            bank = {bank_state.prg_units[3:0], 1'b0} - 5'd2;
                        else
                            bank = {bank_state.prg_units[3:0], 1'b0} - 5'd1;
                        r.target = TGT_PRG_ROM;
                        r.mapped_address = {bank, a[12:0]};
                    end
                    default: ;
                endcase
            end
            MODE_CPU_WR:
            begin
                if (a[15:13] == WIN_PRG_RAM)
                begin
                    r.target = TGT_PRG_RAM;
                    r.mapped_address = {5'd0, a[12:0]};
                end
                else
                begin
                    case (a[15:12])
                        REG_PRG:     bank_state.prg_select  = acc.write_data[3:0];
                        REG_LOW_FD:  bank_state.chr_low_fd  = acc.write_data[4:0];
                        REG_LOW_FE:  bank_state.chr_low_fe  = acc.write_data[4:0];
                        REG_HIGH_FD: bank_state.chr_high_fd = acc.write_data[4:0];
                        REG_HIGH_FE: bank_state.chr_high_fe = acc.write_data[4:0];
                        REG_MIRROR:  bank_state.horiz_mirror = acc.write_data[0];
                        default: ;
                    endcase
                end
            end
            MODE_PPU_RD:
            begin
                if (a <= 16'h0FFF)
                begin
                    // map with the latch from before the fetch
                    bank = bank_state.low_latch_fd ? bank_state.chr_low_fd
                                                   : bank_state.chr_low_fe;
                    r.target = TGT_CHR;
                    r.mapped_address = {1'b0, bank, a[11:0]};
                    if (a == LOW_FD_TRIG)
                        bank_state.low_latch_fd = 1'b1;
                    else if (a == LOW_FE_TRIG)
                        bank_state.low_latch_fd = 1'b0;
                end
                else if (a <= 16'h1FFF)
                begin
                    bank = bank_state.high_latch_fd ? bank_state.chr_high_fd
                                                    : bank_state.chr_high_fe;
                    r.target = TGT_CHR;
                    r.mapped_address = {1'b0, bank, a[11:0]};
                    if (a[15:4] == HIGH_FD_ROW && a[3])
                        bank_state.high_latch_fd = 1'b1;
                    else if (a[15:4] == HIGH_FE_ROW && a[3])
                        bank_state.high_latch_fd = 1'b0;
                end
                else
                begin
                    r.target = TGT_VRAM;
                    r.mapped_address = bank_state.horiz_mirror ? {7'd0, a[11], a[9:0]}
                                                               : {7'd0, a[10:0]};
                end
            end
            default:
            begin
                if (a <= 16'h1FFF)
                begin
                    if (bank_state.chr_ram)
                    begin
                        r.target = TGT_CHR;
                        r.mapped_address = {5'd0, a[12:0]};
                    end
                end
                else
                begin
                    r.target = TGT_VRAM;
                    r.mapped_address = bank_state.horiz_mirror ? {7'd0, a[11], a[9:0]}
                                                               : {7'd0, a[10:0]};
                end
            end
        endcase
        return r;
    endfunction

    function automatic item_t random_access();
        item_t acc;
        int    pick;
        pick = $urandom_range(0, 99);
        acc.write_data = 8'($urandom_range(0, 255));
        acc.address = 16'($urandom_range(0, 65535));
        if (pick < 20)
            acc.mode = MODE_CPU_RD;
        else if (pick < 40)
        begin
            acc.mode = MODE_CPU_WR;
            case ($urandom_range(0, 4))
                0: acc.address = 16'(16'h6000 + $urandom_range(0, 16'h1FFF));
                1: ;
                default: acc.address = 16'(16'hA000 + $urandom_range(0, 16'h5FFF));
            endcase
        end
        else if (pick < 75)
        begin
            acc.mode = MODE_PPU_RD;
            case ($urandom_range(0, 7))
                0: acc.address = LOW_FD_TRIG;
                1: acc.address = LOW_FE_TRIG;
                2: acc.address = 16'({HIGH_FD_ROW, 4'h8} + $urandom_range(0, 7));
                3: acc.address = 16'({HIGH_FE_ROW, 4'h8} + $urandom_range(0, 7));
                // near misses around the triggers
                4: acc.address = {$urandom_range(0, 1) ? 4'h1 : 4'h0, 4'hF,
                                  $urandom_range(0, 1) ? 4'hD : 4'hE,
                                  4'(16'($urandom_range(0, 15)))};
                5: acc.address = 16'($urandom_range(0, 16'h1FFF));
                default: ;
            endcase
        end
        else if (pick < 90)
            acc.mode = MODE_PPU_WR;
        else
            acc.mode = access_mode_t'($urandom_range(0, 3));
        return acc;
    endfunction

    function automatic void add_probe(access_mode_t m, logic [15:0] a, logic [7:0] d,
                                      bit pinned, target_t t, logic [17:0] ma);
        probe_t p;
        p.acc.mode = m;
        p.acc.address = a;
        p.acc.write_data = d;
        p.pinned = pinned;
        p.want.target = t;
        p.want.mapped_address = ma;
        probes.push_back(p);
    endfunction

    task automatic flag_mismatch(string what, result_t want, result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch (%s): expected target %0d addr %05h, got target %0d addr %05h",
                     $realtime, what, want.target, want.mapped_address,
                     got.target, got.mapped_address);
    endtask

    task automatic offer(item_t acc, bit pinned, result_t pin);
        int   gap;
        pin_t p;
        gap = no_wait ? 0 : $urandom_range(0, 6);
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        p.pinned = pinned;
        p.res = pin;
        pinned_maps.push_back(p);
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= acc.mode;
        req_ch.address    <= acc.address;
        req_ch.write_data <= acc.write_data;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_maps.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // result side: random wait per item, long hold on request
    initial
    begin
        int gap;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_rsp)
            begin
                hold_rsp = 1'b0;
                repeat (LONG_HOLD)
                begin
                    @(negedge clk);
                    rsp_ch.ready <= 1'b0;
                end
            end
            gap = no_wait ? 0 : $urandom_range(0, 6);
            repeat (gap)
            begin
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
            end
            @(negedge clk);
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    // acceptance monitor: check results first, then predict new items
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        item_t   acc;
        pin_t    p;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.target = target_t'(rsp_ch.target);
                got.mapped_address = rsp_ch.mapped_address;
                if (pending_maps.size() == 0)
                    flag_mismatch("unexpected item", got, got);
                else
                begin
                    want = pending_maps.pop_front();
                    if (got.target != want.target)
                        flag_mismatch("target", want, got);
                    else if (got.mapped_address != want.mapped_address)
                        flag_mismatch("mapped_address", want, got);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == CFG_PRG_UNITS)
                    bank_state.prg_units = cfg_ch.data;
                else if (cfg_ch.index == CFG_CHR_RAM)
                    bank_state.chr_ram = cfg_ch.data[0];
                else if (cfg_ch.index == CFG_ARRANGE)
                    arrange_vertical = cfg_ch.data[0];  // only read at reset
            end
            if (req_ch.valid && req_ch.ready)
            begin
                acc.mode = access_mode_t'(req_ch.mode);
                acc.address = req_ch.address;
                acc.write_data = req_ch.write_data;
                want = translate_access(acc);
                if (pinned_maps.size() != 0)
                begin
                    p = pinned_maps.pop_front();
                    if (p.pinned)
                        want = p.res;
                end
                pending_maps.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        result_t     no_pin;
        item_t       acc;
        logic [4:0]  units;
        logic [4:0]  chr_val;
        logic [4:0]  arr_val;

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_CPU_RD;
        req_ch.address = '0;
        req_ch.write_data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_PRG_UNITS;
        cfg_ch.data = '0;
        no_pin.target = TGT_NONE;
        no_pin.mapped_address = '0;

        bank_state = '0;
        bank_state.prg_units = PRG_UNITS_RESET;
        bank_state.horiz_mirror = ~VERTICAL_RESET;
        arrange_vertical = VERTICAL_RESET;

        // reset state: PRG 128 KB, CHR ROM, vertical mirroring
        add_probe(MODE_CPU_RD, 16'h0000, 8'h00, 1, TGT_NONE, 18'h00000);
        add_probe(MODE_CPU_RD, 16'h5FFF, 8'hFF, 1, TGT_NONE, 18'h00000);
        add_probe(MODE_CPU_RD, 16'h6000, 8'h00, 1, TGT_PRG_RAM, 18'h00000);
        add_probe(MODE_CPU_WR, 16'h7FFF, 8'hFF, 1, TGT_PRG_RAM, 18'h01FFF);
        add_probe(MODE_CPU_RD, 16'h8000, 8'h00, 1, TGT_PRG_ROM, 18'h00000);
        add_probe(MODE_CPU_RD, 16'hA000, 8'h00, 1, TGT_PRG_ROM, 18'h1A000);
        add_probe(MODE_CPU_RD, 16'hDFFF, 8'h00, 1, TGT_PRG_ROM, 18'h1DFFF);
        add_probe(MODE_CPU_RD, 16'hFFFF, 8'hFF, 1, TGT_PRG_ROM, 18'h1FFFF);
        add_probe(MODE_CPU_WR, 16'h9FFF, 8'hFF, 1, TGT_NONE, 18'h00000);
        add_probe(MODE_PPU_WR, 16'h1FFF, 8'hFF, 1, TGT_NONE, 18'h00000);
        add_probe(MODE_PPU_RD, 16'h3FFF, 8'h00, 1, TGT_VRAM, 18'h007FF);
        add_probe(MODE_PPU_WR, 16'hFFFF, 8'hFF, 1, TGT_VRAM, 18'h007FF);
        // bank registers and mirroring
        add_probe(MODE_CPU_WR, 16'hA000, 8'hFF, 1, TGT_NONE, 18'h00000);
        add_probe(MODE_CPU_WR, 16'hBFFF, 8'hFF, 1, TGT_NONE, 18'h00000);
        add_probe(MODE_CPU_WR, 16'hC123, 8'h35, 1, TGT_NONE, 18'h00000);
        add_probe(MODE_CPU_WR, 16'hD000, 8'h0A, 1, TGT_NONE, 18'h00000);
        add_probe(MODE_CPU_WR, 16'hEFFF, 8'hFF, 1, TGT_NONE, 18'h00000);
        add_probe(MODE_CPU_WR, 16'hF000, 8'h01, 1, TGT_NONE, 18'h00000);
        // latch walk, checked by the predictor
        add_probe(MODE_CPU_RD, 16'h9FFF, 8'h00, 0, TGT_NONE, 18'h0);
        add_probe(MODE_PPU_RD, 16'h0FD8, 8'h00, 0, TGT_NONE, 18'h0);
        add_probe(MODE_PPU_RD, 16'h0000, 8'h00, 0, TGT_NONE, 18'h0);
        add_probe(MODE_PPU_RD, 16'h0FE8, 8'h00, 0, TGT_NONE, 18'h0);
        add_probe(MODE_PPU_RD, 16'h0FD9, 8'h00, 0, TGT_NONE, 18'h0);
        add_probe(MODE_PPU_RD, 16'h1FDF, 8'h00, 0, TGT_NONE, 18'h0);
        add_probe(MODE_PPU_RD, 16'h1FE0, 8'h00, 0, TGT_NONE, 18'h0);
        add_probe(MODE_PPU_RD, 16'h1FE8, 8'h00, 0, TGT_NONE, 18'h0);
        add_probe(MODE_PPU_RD, 16'h2C00, 8'h00, 0, TGT_NONE, 18'h0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (probes[i])
            offer(probes[i].acc, probes[i].pinned, probes[i].want);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: begin units = 5'd2;  chr_val = 5'd1; arr_val = 5'd0; end
                1: begin units = 5'd16; chr_val = 5'd0; arr_val = 5'd1; end
                2: begin units = 5'd0;  chr_val = 5'd1; arr_val = 5'd1; end
                3: begin units = 5'd31; chr_val = 5'd0; arr_val = 5'd0; end
                default:
                begin
                    units = 5'($urandom_range(0, 31));
                    chr_val = 5'($urandom_range(0, 31));
                    arr_val = 5'($urandom_range(0, 31));
                end
            endcase
            write_reg(CFG_PRG_UNITS, units);
            write_reg(CFG_CHR_RAM, chr_val);
            write_reg(CFG_ARRANGE, arr_val);
            if (ph == 0)
                write_reg(CFG_SPARE, 5'd31);

            no_wait = (ph == 3 || ph == 6);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == 2 && n == 20)
                    hold_rsp = 1'b1;      // back up the block and stall its input
                if (ph == 4 && n == 100)
                    drain();
                acc = random_access();
                offer(acc, 1'b0, no_pin);
            end
            drain();
        end

        repeat (4) @(posedge clk);
        if (mismatches == 0 && pending_maps.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/lsbm_pkg.sv
design/lsbm_req_if.sv
design/lsbm_rsp_if.sv
design/lsbm_cfg_if.sv
design/lsbm_bank_regs.sv
design/lsbm_translate.sv
design/lsbm_out_buf.sv
design/latch_switched_bank_mapper.sv
tb/tb_top.sv
